// File: rtl/core/fbfa_pkg.sv
// Shared types and constants of the fixed block free list allocator.
package fbfa_pkg;

    localparam int DEF_MAX_CHUNKS = 256;
    localparam int IDX_W          = 8;
    localparam int CNT_W          = 9;
    localparam int BYTES_W        = 16;
    localparam int REM_W          = 24;
    localparam int CFG_AW         = 3;
    localparam int CFG_DW         = 32;

    localparam logic [CNT_W-1:0]   RST_CHUNKS = 9'd256;
    localparam logic [BYTES_W-1:0] RST_BYTES  = 16'd16;

    localparam logic REG_CHUNKS = 1'b0;
    localparam logic REG_BYTES  = 1'b1;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_QUERY = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0]   chunks_in_use;
        logic [BYTES_W-1:0] chunk_bytes;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic [1:0]       status;
        logic [REM_W-1:0] remaining_bytes;
    } t_result;

endpackage

// File: rtl/core/fixed_block_free_list_allocator_unit.sv
// Top level: fixed-size block pool allocator with a LIFO free list in a link memory.
//
// Requests enter on the input channel (i_in_valid / o_in_ready) with i_func and
// i_chunk_index: allocate, free, clear pool, query. Every request gives exactly one
// result on the output channel (o_out_valid / i_out_ready): granted index, status
// and the free chunk count times the chunk size, saturated to 24 bits.
// Throughput is one request per cycle while the result queue has space, except that an
// allocate served from the stack of freed chunks holds off the next request: the link
// of the new stack top is read from the link memory, whose read data is registered.
// Chunks never freed come from a fresh-index mark in rising order, so reset needs no
// pass over the link memory; after reset the pool of 256 chunks is full, 16 bytes each.
// A two-entry result queue decouples the sides; when the receiver stalls, requests are
// still taken until the queue holds two results, then o_in_ready drops. Configuration
// registers (APB-style, chunks_in_use at 0x0, chunk_bytes at 0x4) are to be written
// by the user only while idle, which the block itself does not enforce; issue a clear
// afterwards to rebuild the pool.
module fixed_block_free_list_allocator_unit #(
    parameter int MAX_CHUNKS = fbfa_pkg::DEF_MAX_CHUNKS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fbfa_pkg::CFG_AW-1:0]  paddr,
    input  logic [fbfa_pkg::CFG_DW-1:0]  pwdata,
    output logic [fbfa_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_func,
    input  logic [fbfa_pkg::IDX_W-1:0]   i_chunk_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [fbfa_pkg::IDX_W-1:0]   o_granted_index,
    output logic [1:0]                   o_status,
    output logic [fbfa_pkg::REM_W-1:0]   o_remaining_bytes
);
    import fbfa_pkg::*;

    localparam int LINK_DEPTH = (MAX_CHUNKS < 256) ? MAX_CHUNKS : 256;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam logic [CNT_W-1:0] POOL_MAX = CNT_W'(LINK_DEPTH);
    localparam int PROD_W = CNT_W + BYTES_W;

    t_cfg    cfg;
    t_result res;
    t_result q_data;
    logic    q_space;
    logic    in_fire;

    logic [IDX_W-1:0] r_stack_top, n_stack_top;
    logic [IDX_W-1:0] r_top_link, n_top_link;
    logic             r_stack_nonempty, n_stack_nonempty;
    logic [CNT_W-1:0] r_fresh, n_fresh;
    logic [CNT_W-1:0] r_free_count, n_free_count;
    logic             r_pend, n_pend;

    logic [CNT_W-1:0]   pool_n;
    logic [CNT_W-1:0]   fresh_left;
    logic [CNT_W-1:0]   count_dec;
    logic [PROD_W-1:0]  prod;
    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_data;
    logic [IDX_W-1:0]   granted;
    t_status            status;

    fbfa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fbfa_link_mem #(
        .DEPTH (LINK_DEPTH),
        .AW    (LINK_AW)
    ) u_link (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_chunk_index[LINK_AW-1:0]),
        .i_wr_data (r_stack_top),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_top_link[LINK_AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Hold input while the link of a freshly popped stack top is in flight.
    assign o_in_ready = !r_pend & q_space;
    assign in_fire    = i_in_valid & o_in_ready;

    assign pool_n     = (cfg.chunks_in_use > POOL_MAX) ? POOL_MAX : cfg.chunks_in_use;
    assign fresh_left = (r_fresh < pool_n) ? (pool_n - r_fresh) : '0;
    assign count_dec  = (r_free_count != '0) ? (r_free_count - CNT_W'(1)) : r_free_count;

    always_comb begin
        n_stack_top      = r_stack_top;
        n_top_link       = r_top_link;
        n_stack_nonempty = r_stack_nonempty;
        n_fresh          = r_fresh;
        n_free_count     = r_free_count;
        n_pend           = 1'b0;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        granted          = '0;
        status           = ST_OK;
        if (in_fire) begin
            unique case (t_func'(i_func))
                FUNC_ALLOC: begin
                    if (r_stack_nonempty) begin
                        granted          = r_stack_top;
                        n_stack_top      = r_top_link;
                        n_free_count     = count_dec;
                        n_stack_nonempty = count_dec > fresh_left;
                        rd_en            = 1'b1;
                        n_pend           = 1'b1;
                    end else if (r_fresh < pool_n) begin
                        granted      = r_fresh[IDX_W-1:0];
                        n_fresh      = r_fresh + CNT_W'(1);
                        n_free_count = count_dec;
                    end else begin
                        status = ST_OOM;
                    end
                end
                FUNC_FREE: begin
                    if ({1'b0, i_chunk_index} >= pool_n) begin
                        status = ST_RANGE;
                    end else begin
                        wr_en            = 1'b1;
                        n_stack_top      = i_chunk_index;
                        n_top_link       = r_stack_top;
                        n_stack_nonempty = 1'b1;
                        if (r_free_count != '1) begin
                            n_free_count = r_free_count + CNT_W'(1);
                        end
                    end
                end
                FUNC_CLEAR: begin
                    n_stack_top      = '0;
                    n_stack_nonempty = 1'b0;
                    n_fresh          = '0;
                    n_free_count     = pool_n;
                end
                FUNC_QUERY: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_top      <= '0;
            r_stack_nonempty <= 1'b0;
            r_fresh          <= '0;
            r_free_count     <= RST_CHUNKS;
            r_pend           <= 1'b0;
        end else begin
            r_stack_top      <= n_stack_top;
            r_stack_nonempty <= n_stack_nonempty;
            r_fresh          <= n_fresh;
            r_free_count     <= n_free_count;
            r_pend           <= n_pend;
        end
    end

    // Take the link read back into the cached link of the stack top.
    always_ff @(posedge i_clk) begin
        r_top_link <= r_pend ? rd_data : n_top_link;
    end

    assign prod = PROD_W'(n_free_count) * PROD_W'(cfg.chunk_bytes);

    always_comb begin
        res.granted_index   = granted;
        res.status          = status;
        res.remaining_bytes = (prod > PROD_W'({REM_W{1'b1}})) ? {REM_W{1'b1}}
                                                              : prod[REM_W-1:0];
    end

    fbfa_out_queue u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire),
        .i_data  (res),
        .o_space (q_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (q_data)
    );

    assign o_granted_index   = q_data.granted_index;
    assign o_status          = q_data.status;
    assign o_remaining_bytes = q_data.remaining_bytes;

    a_pend_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_in_ready)
        else $error("request taken while a link read is in flight");

    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_func == FUNC_ALLOC && r_stack_nonempty) |=> r_pend)
        else $error("stack pop did not fetch the next link");

    a_pend_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> !r_pend)
        else $error("link read pending for more than one cycle");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_func == FUNC_CLEAR) |=>
            (!r_stack_nonempty && r_fresh == '0 && r_free_count == $past(pool_n)))
        else $error("clear did not restore the pool");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_func == FUNC_ALLOC && !r_stack_nonempty && r_fresh >= pool_n)
            |=> (r_fresh == $past(r_fresh)))
        else $error("fresh mark moved past the pool");

endmodule

// File: rtl/core/fbfa_link_mem.sv
// Link memory: next-chunk link of every pushed chunk, one write and one read port.
module fbfa_link_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [fbfa_pkg::IDX_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [fbfa_pkg::IDX_W-1:0] o_rd_data
);
    import fbfa_pkg::*;

    logic [IDX_W-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/fbfa_cfg_regs.sv
// Configuration registers behind the APB-style port.
module fbfa_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbfa_pkg::CFG_AW-1:0] paddr,
    input  logic [fbfa_pkg::CFG_DW-1:0] pwdata,
    output logic [fbfa_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output fbfa_pkg::t_cfg              o_cfg
);
    import fbfa_pkg::*;

    t_cfg r_cfg;
    logic reg_sel;
    logic wr_fire;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_fire = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chunks_in_use <= RST_CHUNKS;
            r_cfg.chunk_bytes   <= RST_BYTES;
        end else if (wr_fire) begin
            if (reg_sel == REG_CHUNKS) begin
                r_cfg.chunks_in_use <= pwdata[CNT_W-1:0];
            end else begin
                r_cfg.chunk_bytes <= pwdata[BYTES_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_CHUNKS: prdata = {{(CFG_DW-CNT_W){1'b0}}, r_cfg.chunks_in_use};
            REG_BYTES:  prdata = {{(CFG_DW-BYTES_W){1'b0}}, r_cfg.chunk_bytes};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/fbfa_out_queue.sv
// Two-entry result queue between the allocator core and the result channel.
module fbfa_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fbfa_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output fbfa_pkg::t_result o_data
);
    import fbfa_pkg::*;

    t_result    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign pop     = o_valid & i_ready;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
